@@ rtl/debounce_short_long_press_macros.svh @@
`ifndef DEBOUNCE_SHORT_LONG_PRESS_MACROS_SVH
`define DEBOUNCE_SHORT_LONG_PRESS_MACROS_SVH

// same-cycle implication, disabled during reset
`define DSLP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DSLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/dslp_pkg.sv @@
`default_nettype none

package dslp_pkg;

   localparam int BUTTONS_W = 6;
   localparam int CODE_W    = 3;
   localparam int TICKS_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [TICKS_W-1:0] DEBOUNCE_TICKS_RESET = 16'd50;
   localparam logic [TICKS_W-1:0] LONG_TICKS_RESET     = 16'd1000;
   localparam logic [TICKS_W-1:0] TICKS_MAX            = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS     = 2'd1;

   localparam logic [CODE_W-1:0] KEY_NONE   = 3'd0;
   localparam logic [CODE_W-1:0] KEY_UP     = 3'd1;
   localparam logic [CODE_W-1:0] KEY_RIGHT  = 3'd2;
   localparam logic [CODE_W-1:0] KEY_LEFT   = 3'd3;
   localparam logic [CODE_W-1:0] KEY_DOWN   = 3'd4;
   localparam logic [CODE_W-1:0] KEY_CENTER = 3'd5;
   localparam logic [CODE_W-1:0] KEY_BLUE   = 3'd6;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] key_code;
      logic              long_press;
   } event_type;

   // highest priority rising edge
   function automatic logic [CODE_W-1:0] pick_edge(input logic [BUTTONS_W-1:0] edges);
      logic [CODE_W-1:0] code;
      begin
         if (edges[4]) code = KEY_CENTER;
         else if (edges[3]) code = KEY_DOWN;
         else if (edges[5]) code = KEY_BLUE;
         else if (edges[2]) code = KEY_LEFT;
         else if (edges[1]) code = KEY_RIGHT;
         else if (edges[0]) code = KEY_UP;
         else code = KEY_NONE;
         return code;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/debounce_short_long_press.sv @@
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req_buttons[5:0]
//  rsp     | out       | rsp_valid, rsp_stall | rsp_key_code[2:0], rsp_long_press
//  csr     | in        | csr_write_enable     | csr_index[1:0], csr_write_data[15:0]
//
//  one tick per cycle while req_stall is low: a transaction is taken in each such cycle
//  and its event, if any, is registered in the output register, or in the skid register
//  if the output is stalled; a skid register holds one event while rsp_stall is high;
//  req_stall rises only when the skid register is full
//  reset is synchronous, active high, and restores the register defaults
`default_nettype none

`include "debounce_short_long_press_macros.svh"

module debounce_short_long_press (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [dslp_pkg::BUTTONS_W-1:0]      req_buttons,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [dslp_pkg::CODE_W-1:0]              rsp_key_code,
   output logic                                     rsp_long_press,
   input  wire logic                                csr_write_enable,
   input  wire logic [dslp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dslp_pkg::TICKS_W-1:0]        csr_write_data
);

   import dslp_pkg::*;

   logic [TICKS_W-1:0]   debounce_ticks_ff, debounce_ticks_in;
   logic [TICKS_W-1:0]   long_ticks_ff, long_ticks_in;
   logic [BUTTONS_W-1:0] prev_levels_ff, prev_levels_in;
   logic [CODE_W-1:0]    selected_ff, selected_in;
   logic [TICKS_W-1:0]   debounce_count_ff, debounce_count_in;
   logic [TICKS_W-1:0]   hold_count_ff, hold_count_in;
   logic                 long_reached_ff, long_reached_in;
   event_type            out_ff, out_in;
   event_type            skid_ff, skid_in;

   logic                 accept;
   logic [BUTTONS_W-1:0] edges;
   logic [CODE_W-1:0]    edge_code;
   logic [TICKS_W-1:0]   hold_next;
   logic [TICKS_W-1:0]   debounce_next;
   logic [TICKS_W-1:0]   period;
   logic [CODE_W-1:0]    sel_bit;
   logic                 long_next;
   event_type            result;
   logic                 out_free;

   assign req_stall      = skid_ff.valid;
   assign accept         = req_valid && !req_stall;
   assign rsp_valid      = out_ff.valid;
   assign rsp_key_code   = out_ff.key_code;
   assign rsp_long_press = out_ff.long_press;

   assign edges     = req_buttons & ~prev_levels_ff;
   assign edge_code = pick_edge(edges);
   assign period    = (debounce_ticks_ff == '0) ? TICKS_W'(1) : debounce_ticks_ff;
   assign hold_next = (hold_count_ff == TICKS_MAX) ? hold_count_ff
                                                   : hold_count_ff + TICKS_W'(1);
   assign long_next = long_reached_ff || (hold_next >= long_ticks_ff);
   assign debounce_next = debounce_count_ff + TICKS_W'(1);
   assign sel_bit   = selected_ff - CODE_W'(1);

   always_comb begin
      debounce_ticks_in = debounce_ticks_ff;
      long_ticks_in     = long_ticks_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ticks_in = csr_write_data;
            CSR_LONG_TICKS:     long_ticks_in     = csr_write_data;
            default: ;
         endcase
      end
   end

   // tick processing
   always_comb begin
      prev_levels_in    = prev_levels_ff;
      selected_in       = selected_ff;
      debounce_count_in = debounce_count_ff;
      hold_count_in     = hold_count_ff;
      long_reached_in   = long_reached_ff;
      result            = '0;
      if (accept) begin
         prev_levels_in = req_buttons;
         if (edge_code != KEY_NONE) begin
            selected_in       = edge_code;
            debounce_count_in = '0;
            hold_count_in     = '0;
            long_reached_in   = 1'b0;
         end else if (selected_ff != KEY_NONE) begin
            hold_count_in     = hold_next;
            long_reached_in   = long_next;
            debounce_count_in = debounce_next;
            if (debounce_next >= period) begin
               debounce_count_in = '0;
               if (!req_buttons[sel_bit]) begin
                  result.valid      = 1'b1;
                  result.key_code   = selected_ff;
                  result.long_press = long_next;
                  selected_in       = KEY_NONE;
                  hold_count_in     = '0;
                  long_reached_in   = 1'b0;
               end
            end
         end
      end
   end

   // output register and skid
   assign out_free = !out_ff.valid || !rsp_stall;

   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (skid_ff.valid) begin
         if (!rsp_stall) begin
            out_in        = skid_ff;
            skid_in.valid = 1'b0;
         end
      end else if (out_free) begin
         out_in = result;
      end else if (result.valid) begin
         skid_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_TICKS_RESET;
         long_ticks_ff     <= LONG_TICKS_RESET;
         prev_levels_ff    <= '0;
         selected_ff       <= KEY_NONE;
         debounce_count_ff <= '0;
         hold_count_ff     <= '0;
         long_reached_ff   <= 1'b0;
         out_ff            <= '0;
         skid_ff           <= '0;
      end else begin
         debounce_ticks_ff <= debounce_ticks_in;
         long_ticks_ff     <= long_ticks_in;
         prev_levels_ff    <= prev_levels_in;
         selected_ff       <= selected_in;
         debounce_count_ff <= debounce_count_in;
         hold_count_ff     <= hold_count_in;
         long_reached_ff   <= long_reached_in;
         out_ff            <= out_in;
         skid_ff           <= skid_in;
      end
   end

   `DSLP_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_ff.valid, out_ff.valid,
      "skid holds an event while output register is empty")
   `DSLP_ASSERT_SAME(a_idle_counters, clock, reset, selected_ff == KEY_NONE,
      debounce_count_ff == '0 && hold_count_ff == '0 && !long_reached_ff,
      "counters running with no button selected")
   `DSLP_ASSERT_SAME(a_code_range, clock, reset, out_ff.valid,
      out_ff.key_code != KEY_NONE && out_ff.key_code <= KEY_BLUE,
      "event with invalid key code")
   `DSLP_ASSERT_NEXT(a_skid_drain, clock, reset, skid_ff.valid && !rsp_stall,
      out_ff.valid && !skid_ff.valid, "skid event not moved to output register")

endmodule

`default_nettype wire
